// ===== hdl/gif_literal_lzw_code_packer_assert.svh =====
// assertion macros for the literal lzw code packer
`ifndef GIF_LITERAL_LZW_CODE_PACKER_ASSERT_SVH
`define GIF_LITERAL_LZW_CODE_PACKER_ASSERT_SVH

// checked property, skipped while in reset
`define GLCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds in reset
`define GLCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/glcp_pkg.sv =====
`default_nettype none

package glcp_pkg;

    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 9;
    localparam int WID_W      = 4;
    localparam int MCS_W      = 4;
    localparam int ACC_W      = 24;
    localparam int CNT_W      = 5;
    localparam int APPEND_MAX = 15;

    localparam logic [MCS_W-1:0] MCS_RESET = 4'd8;
    localparam logic [MCS_W-1:0] MCS_MIN   = 4'd2;
    localparam logic [MCS_W-1:0] MCS_MAX   = 4'd8;

    localparam logic [CODE_W-1:0] CLEAR_MARGIN = 9'd4;

    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_CLEAR = 3'b001,
        PH_LIT   = 3'b010,
        PH_END   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [WID_W-1:0]  width;
        logic              is_end;
    } code_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             flush;
        logic             pop;
    } back_stat_t;

    function automatic logic [MCS_W-1:0] eff_size(input logic [MCS_W-1:0] raw);
        logic [MCS_W-1:0] m;
        m = raw;
        if (raw < MCS_MIN)
            m = MCS_MIN;
        else if (raw > MCS_MAX)
            m = MCS_MAX;
        return m;
    endfunction

    function automatic logic [CODE_W-1:0] clear_value(input logic [MCS_W-1:0] m);
        return CODE_W'(1) << m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/glcp_front.sv =====
`default_nettype none

module glcp_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [glcp_pkg::MCS_W-1:0]   min_size,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [7:0]                   pixel_index,
    input  wire logic                         last_pixel,
    output logic                              push_valid,
    output glcp_pkg::code_t                   push_entry,
    input  wire logic                         push_full
);
    import glcp_pkg::*;

    logic                item_valid_reg, item_valid_next;
    phase_t              phase_reg, phase_next;
    logic [MCS_W-1:0]    m_reg, m_next;
    logic [CODE_W-1:0]   pix_reg, pix_next;
    logic                last_reg, last_next;
    logic [7:0]          lit_cnt_reg, lit_cnt_next;
    logic                frame_open_reg, frame_open_next;

    logic                pushed;
    logic                final_code;
    logic                accept;
    logic                need_clear;
    logic [CODE_W-1:0]   limit;
    logic [7:0]          pix_mask;

    always_comb
    begin
        push_valid = item_valid_reg;
        push_entry.width  = m_reg + WID_W'(1);
        push_entry.is_end = 1'b0;
        case (phase_reg)
            PH_CLEAR: push_entry.code = clear_value(m_reg);
            PH_LIT:   push_entry.code = pix_reg;
            PH_END:
            begin
                push_entry.code   = clear_value(m_reg) | CODE_W'(1);
                push_entry.is_end = 1'b1;
            end
            default:  push_entry.code = pix_reg;
        endcase
    end

    assign pushed     = item_valid_reg && !push_full;
    assign final_code = (phase_reg == PH_END) || ((phase_reg == PH_LIT) && !last_reg);
    assign in_stall   = item_valid_reg && !(pushed && final_code);
    assign accept     = in_valid && !in_stall;

    assign limit      = (min_size == MCS_MIN) ? CODE_W'(1) : clear_value(min_size) - CLEAR_MARGIN;
    assign need_clear = !frame_open_reg || ({1'b0, lit_cnt_reg} >= limit);
    assign pix_mask   = 8'hFF >> (4'd8 - min_size);

    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        m_next          = m_reg;
        pix_next        = pix_reg;
        last_next       = last_reg;
        lit_cnt_next    = lit_cnt_reg;
        frame_open_next = frame_open_reg;

        if (pushed)
        begin
            case (phase_reg)
                PH_CLEAR: phase_next = PH_LIT;
                PH_LIT:   phase_next = PH_END;
                PH_END:   phase_next = PH_LIT;
                default:  phase_next = PH_LIT;
            endcase
            if (final_code)
                item_valid_next = 1'b0;
        end

        if (accept)
        begin
            item_valid_next = 1'b1;
            phase_next      = need_clear ? PH_CLEAR : PH_LIT;
            m_next          = min_size;
            pix_next        = {1'b0, pixel_index & pix_mask};
            last_next       = last_pixel;
            if (last_pixel)
            begin
                lit_cnt_next    = 8'd0;
                frame_open_next = 1'b0;
            end
            else
            begin
                lit_cnt_next    = need_clear ? 8'd1 : lit_cnt_reg + 8'd1;
                frame_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_LIT;
            lit_cnt_reg    <= 8'd0;
            frame_open_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            lit_cnt_reg    <= lit_cnt_next;
            frame_open_reg <= frame_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        pix_reg  <= pix_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

// ===== hdl/glcp_fifo.sv =====
`default_nettype none

module glcp_fifo #(
    parameter int DEPTH = glcp_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push_valid,
    input  wire glcp_pkg::code_t            push_entry,
    output logic                            full,
    input  wire logic                       pop,
    output glcp_pkg::code_t                 pop_entry,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      level
);
    import glcp_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH+1);

    code_t            mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_push, do_pop;

    assign full      = (level_reg == LW'(DEPTH));
    assign empty     = (level_reg == '0);
    assign level     = level_reg;
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            level_next = level_reg + LW'(1);
        else if (do_pop && !do_push)
            level_next = level_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== hdl/glcp_back.sv =====
`default_nettype none

module glcp_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire glcp_pkg::code_t      code_entry,
    input  wire logic                 code_empty,
    output logic                      code_pop,
    output glcp_pkg::back_stat_t      stat,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                data_byte,
    output logic                      last_byte
);
    import glcp_pkg::*;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        data_reg, data_next;
    logic              last_reg, last_next;

    logic              emit_ok, can_emit, do_emit, ends_flush;
    logic [ACC_W-1:0]  post_acc;
    logic [CNT_W-1:0]  post_cnt;
    logic              post_flush;

    assign emit_ok    = !out_valid_reg || !out_stall;
    assign can_emit   = (cnt_reg >= CNT_W'(BYTE_W)) || (flush_reg && (cnt_reg != '0));
    assign do_emit    = emit_ok && can_emit;
    assign ends_flush = flush_reg && (cnt_reg <= CNT_W'(BYTE_W));

    always_comb
    begin
        post_acc   = acc_reg;
        post_cnt   = cnt_reg;
        post_flush = flush_reg;
        if (do_emit)
        begin
            post_acc = acc_reg >> BYTE_W;
            post_cnt = (cnt_reg > CNT_W'(BYTE_W)) ? cnt_reg - CNT_W'(BYTE_W) : '0;
            if (ends_flush)
                post_flush = 1'b0;
        end
    end

    assign code_pop = !code_empty && !post_flush && (post_cnt <= CNT_W'(APPEND_MAX));

    always_comb
    begin
        acc_next   = post_acc;
        cnt_next   = post_cnt;
        flush_next = post_flush;
        if (code_pop)
        begin
            acc_next   = post_acc | (ACC_W'(code_entry.code) << post_cnt[3:0]);
            cnt_next   = post_cnt + CNT_W'(code_entry.width);
            flush_next = code_entry.is_end;
        end

        out_valid_next = out_valid_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        if (do_emit)
        begin
            out_valid_next = 1'b1;
            data_next      = acc_reg[7:0];
            last_next      = ends_flush;
        end
        else if (emit_ok)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            flush_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            flush_reg     <= flush_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_reg;
    assign last_byte  = last_reg;
    assign stat.cnt   = cnt_reg;
    assign stat.flush = flush_reg;
    assign stat.pop   = code_pop;

endmodule

`default_nettype wire

// ===== hdl/gif_literal_lzw_code_packer.sv =====
// Literal-only GIF LZW code packer: one palette index in, packed code-stream
// bytes out, least significant bit first. The front end turns each pixel into
// one code per cycle while the queue is not full (clear code at frame start and
// at the literal limit, the literal, then the end code after the last pixel) and
// queues them; the back end appends one code per cycle to a 24-bit bit buffer
// while it has room and no flush is pending, and sends one byte per cycle while
// out_stall allows, flushing the partial byte at frame end with last_byte set.
// The front end takes a new pixel only as the last code of the previous one is
// queued. Sustained rate is one pixel per cycle while codes are at most eight
// bits wide and the output does not stall; with nine-bit codes the byte output
// sets it. Each clear code takes one more front-end push and adds its bits to
// the output. A pixel's codes pass from the front-end registers through the code
// queue into the bit buffer, and each byte is registered before it goes out.
`default_nettype none

`include "gif_literal_lzw_code_packer_assert.svh"

module gif_literal_lzw_code_packer #(
    parameter int FIFO_DEPTH = glcp_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [glcp_pkg::MCS_W-1:0]  cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  pixel_index,
    input  wire logic                        last_pixel,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [7:0]                       data_byte,
    output logic                             last_byte
);
    import glcp_pkg::*;

    logic [MCS_W-1:0]            mcs_reg, mcs_next;
    logic                        push_valid, push_full;
    code_t                       push_entry, pop_entry;
    logic                        code_empty, code_pop;
    logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_level;
    back_stat_t                  back_stat;

    assign mcs_next = cfg_wr_en ? cfg_wr_data : mcs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mcs_reg <= MCS_RESET;
        else
            mcs_reg <= mcs_next;
    end

    glcp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .min_size    (eff_size(mcs_reg)),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_index (pixel_index),
        .last_pixel  (last_pixel),
        .push_valid  (push_valid),
        .push_entry  (push_entry),
        .push_full   (push_full)
    );

    glcp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (push_full),
        .pop        (code_pop),
        .pop_entry  (pop_entry),
        .empty      (code_empty),
        .level      (fifo_level)
    );

    glcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_entry (pop_entry),
        .code_empty (code_empty),
        .code_pop   (code_pop),
        .stat       (back_stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte)
    );

    // bit buffer never overruns and codes of the next frame wait for the flush
    `GLCP_ASSERT(a_cnt_range, back_stat.cnt <= CNT_W'(ACC_W), "bit buffer overrun")
    `GLCP_ASSERT(a_no_pop_in_flush, back_stat.flush && back_stat.cnt > CNT_W'(BYTE_W) |-> !back_stat.pop, "code appended during flush")
    `GLCP_ASSERT(a_fifo_level, fifo_level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH), "code queue level out of range")
    `GLCP_ASSERT(a_last_needs_flush, $rose(out_valid) && last_byte |-> $past(back_stat.flush), "last byte without flush")

endmodule

`default_nettype wire
